>>> sv/oqt_pkg.sv
// ----------------------------------------------------------------------------
// oqt_pkg
// Shared types, codes and sizes for the ordered queue table.
// ----------------------------------------------------------------------------
package oqt_pkg;

  // Storage size and derived widths
  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Field widths of the transfer payloads
  localparam int FUNC_W = 3;
  localparam int OPND_W = 32;
  localparam int POS_W  = 6;
  localparam int VAL_W  = 31;
  localparam int ST_W   = 2;
  localparam int OCC_W  = 7;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_PUSH   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_POP    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ERASE  = 3'd3;
  localparam logic [FUNC_W-1:0] FN_GET    = 3'd4;
  localparam logic [FUNC_W-1:0] FN_CLEAR  = 3'd5;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_NEG   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [OPND_W-1:0] operand_value;
    logic [POS_W-1:0]         position;
  } oqt_in_t;

  typedef struct packed {
    logic [VAL_W-1:0] read_value;
    logic [ST_W-1:0]  status;
    logic [OCC_W-1:0] occupancy;
  } oqt_out_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic             shift;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [VAL_W-1:0] wr_data;
  } oqt_cell_ctl_t;

endpackage

>>> sv/oqt_cell.sv
// ----------------------------------------------------------------------------
// oqt_cell
// One storage cell of the queue chain: loads the broadcast value when its
// index is addressed, otherwise takes its right neighbor on a shift.
// ----------------------------------------------------------------------------
module oqt_cell
  import oqt_pkg::*;
(
  input  logic                clk,
  input  logic [IDX_W-1:0]    cell_idx,
  input  oqt_cell_ctl_t       ctl,
  input  logic [VAL_W-1:0]    nbr_val,
  output logic [VAL_W-1:0]    cell_val
);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;

  // Select write, shift or hold
  always_comb begin
    data_nxt = data_r;
    if (ctl.wr_en && (ctl.wr_idx == cell_idx)) begin
      data_nxt = ctl.wr_data;
    end else if (ctl.shift) begin
      data_nxt = nbr_val;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign cell_val = data_r;

endmodule

>>> sv/oqt_ctrl.sv
// ----------------------------------------------------------------------------
// oqt_ctrl
// Sequencer of the queue: decodes each operation, rotates the cell chain
// through the head one entry a cycle, and registers the result.
// ----------------------------------------------------------------------------
module oqt_ctrl
  import oqt_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  oqt_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output oqt_out_t         out_data,
  input  logic [VAL_W-1:0] head_val,
  output oqt_cell_ctl_t    ctl
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  // Control state
  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic [CNT_W-1:0] step_r, step_nxt;
  logic             pend_r, pend_nxt;
  logic             out_valid_r, out_valid_nxt;

  // Payload state
  logic [FUNC_W-1:0] op_r, op_nxt;
  logic [VAL_W-1:0]  val_r, val_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [VAL_W-1:0]  rdata_r, rdata_nxt;
  logic [ST_W-1:0]   st_r, st_nxt;
  oqt_out_t          out_r, out_nxt;

  logic keep;
  logic neg;
  logic full;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign neg       = in_data.operand_value[OPND_W-1];
  assign full      = (cnt_r >= CNT_W'(CAPACITY));

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    remain_nxt    = remain_r;
    step_nxt      = step_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    op_nxt        = op_r;
    val_nxt       = val_r;
    pos_nxt       = pos_r;
    rdata_nxt     = rdata_r;
    st_nxt        = st_r;
    out_nxt       = out_r;
    keep          = 1'b1;
    ctl           = '0;
    ctl.wr_data   = head_val;

    // Drop the result once it is transferred
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_data.func;
          val_nxt    = in_data.operand_value[VAL_W-1:0];
          pos_nxt    = in_data.position;
          step_nxt   = '0;
          rdata_nxt  = '0;
          pend_nxt   = 1'b0;
          remain_nxt = '0;
          st_nxt     = ST_OK;
          state_nxt  = S_RUN;
          unique case (in_data.func) inside
            FN_PUSH, FN_INSERT: begin
              if (neg) begin
                st_nxt = ST_NEG;
              end else if (full) begin
                st_nxt = ST_FULL;
              end else begin
                pend_nxt = 1'b1;
                if (in_data.func == FN_INSERT) begin
                  remain_nxt = cnt_r;
                end
              end
            end
            FN_POP: begin
              if (cnt_r == '0) begin
                st_nxt = ST_EMPTY;
              end else begin
                remain_nxt = CNT_W'(1);
              end
            end
            FN_ERASE: begin
              st_nxt = ST_EMPTY;
              if (!neg) begin
                remain_nxt = cnt_r;
              end
            end
            FN_GET: begin
              if (32'(in_data.position) < 32'(cnt_r)) begin
                remain_nxt = cnt_r;
              end else begin
                st_nxt = ST_EMPTY;
              end
            end
            FN_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      S_RUN: begin
        if (pend_r && ((remain_r == '0) || !(head_val > val_r))) begin
          // Append the new value behind the current tail
          ctl.wr_en   = 1'b1;
          ctl.wr_idx  = IDX_W'(cnt_r);
          ctl.wr_data = val_r;
          cnt_nxt     = cnt_r + CNT_W'(1);
          pend_nxt    = 1'b0;
        end else if (remain_r != '0) begin
          // Rotate the head out; re-append it unless it is dropped
          if (op_r == FN_POP) begin
            keep = 1'b0;
          end else if ((op_r == FN_ERASE) && (head_val == val_r)) begin
            keep   = 1'b0;
            st_nxt = ST_OK;
          end
          if ((op_r == FN_POP) ||
              ((op_r == FN_GET) && (32'(step_r) == 32'(pos_r)))) begin
            rdata_nxt = head_val;
          end
          ctl.shift  = 1'b1;
          ctl.wr_en  = keep;
          ctl.wr_idx = IDX_W'(cnt_r - CNT_W'(1));
          if (!keep) begin
            cnt_nxt = cnt_r - CNT_W'(1);
          end
          remain_nxt = remain_r - CNT_W'(1);
          step_nxt   = step_r + CNT_W'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_nxt.read_value = rdata_r;
          out_nxt.status     = st_r;
          out_nxt.occupancy  = OCC_W'(cnt_r);
          out_valid_nxt      = 1'b1;
          state_nxt          = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      remain_r    <= '0;
      step_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      remain_r    <= remain_nxt;
      step_r      <= step_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    val_r   <= val_nxt;
    pos_r   <= pos_nxt;
    rdata_r <= rdata_nxt;
    st_r    <= st_nxt;
    out_r   <= out_nxt;
  end

  // Occupancy never passes the capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  // An append only happens with room left in the chain
  a_append_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.wr_en && !ctl.shift) |-> (cnt_r < CNT_W'(CAPACITY)))
    else $error("append into a full chain");

  // Every accepted item starts a run
  a_accept_run: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_RUN))
    else $error("accepted item did not start a run");

  // A run ends once nothing is left to rotate or append
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_RUN) && (remain_r == '0) && !pend_r) |=> (state_r == S_DONE))
    else $error("run did not finish");

  // Chain moves only while running
  a_ctl_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RUN) |-> (!ctl.shift && !ctl.wr_en))
    else $error("chain written outside a run");

endmodule

>>> sv/ordered_queue_table_top.sv
// ----------------------------------------------------------------------------
// ordered_queue_table_top
// Bounded ordered queue built as a chain of storage cells with a sequencer.
// ----------------------------------------------------------------------------
// Sequence: clear, spare codes and rejected items run with no move of the chain;
// push appends once, pop rotates the head out once, erase and an in-range get
// rotate every held entry, and insert rotates every held entry and appends once.
// Throughput: one item at a time; the next transfer is taken the cycle after
// the result is registered, which waits while the output is stalled.
// Reset: synchronous, active low; the queue comes up empty, cells keep contents.
module ordered_queue_table_top
  import oqt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  oqt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output oqt_out_t out_data
);

  oqt_cell_ctl_t    ctl;
  logic [VAL_W-1:0] cell_q [CAPACITY];

  oqt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .head_val  (cell_q[0]),
    .ctl       (ctl)
  );

  // Build the cell chain; each cell shifts from its right neighbor
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VAL_W-1:0] nbr;
    if (i < CAPACITY - 1) begin : g_mid
      assign nbr = cell_q[i+1];
    end else begin : g_last
      assign nbr = cell_q[i];
    end
    oqt_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .ctl      (ctl),
      .nbr_val  (nbr),
      .cell_val (cell_q[i])
    );
  end

endmodule
